@@ hw/rtl/sync_length_checksum_deframer_top_macros.svh @@
// ---------------------------------------------------------------------------
// sync length checksum deframer assertion macros
// shared property wrappers for the deframer checks, clocked on clk and
// disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define SLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/slcd_pkg.sv @@
// ---------------------------------------------------------------------------
// slcd_pkg
// shared constants, status codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package slcd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = 7;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
  localparam logic [CNT_W-1:0]  LIMIT_MAX  = CNT_W'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic    ld_len;
    logic    pay_wr;
    logic    rd_en;
    logic    emit_data;
    logic    emit_status;
    status_t st_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_too_long;
    logic len_zero;
    logic pay_done;
    logic sum_match;
    logic frame_empty;
    logic emit_last;
    logic out_busy;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/slcd_ctrl.sv @@
// ---------------------------------------------------------------------------
// slcd_ctrl
// frame state machine: hunt, length, payload, check byte and payload drain
// ---------------------------------------------------------------------------
module slcd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 start_hit,
  input  slcd_pkg::dp_stat_t   stat,
  output slcd_pkg::ctrl_cmd_t  cmd
);
  import slcd_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT,
    S_LEN,
    S_PAY,
    S_CHK,
    S_RD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_comb begin
    unique case (state_r)
      S_HUNT, S_PAY: in_ready = 1'b1;
      S_LEN, S_CHK:  in_ready = !stat.out_busy;
      default:       in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.st_code = ST_GOOD;
    state_nxt = state_r;
    unique case (state_r)
      S_HUNT: begin
        if (accept && start_hit) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd.ld_len = 1'b1;
          if (stat.len_too_long) begin
            cmd.emit_status = 1'b1;
            cmd.st_code     = ST_TOO_LONG;
            state_nxt       = S_HUNT;
          end else if (stat.len_zero) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_PAY;
          end
        end
      end
      S_PAY: begin
        if (accept) begin
          cmd.pay_wr = 1'b1;
          if (stat.pay_done) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (accept) begin
          if (!stat.sum_match) begin
            cmd.emit_status = 1'b1;
            cmd.st_code     = ST_BAD_SUM;
            state_nxt       = S_HUNT;
          end else if (stat.frame_empty) begin
            cmd.emit_status = 1'b1;
            cmd.st_code     = ST_GOOD;
            state_nxt       = S_HUNT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt     = stat.emit_last ? S_HUNT : S_RD;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/slcd_dp.sv @@
// ---------------------------------------------------------------------------
// slcd_dp
// deframer datapath: limit register, counters, checksum, payload memory
// and the output register
// ---------------------------------------------------------------------------
module slcd_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [slcd_pkg::BYTE_W-1:0]           in_rx_byte,
  input  logic                                  cfg_valid,
  input  logic [slcd_pkg::CNT_W-1:0]            cfg_max_payload,
  input  slcd_pkg::ctrl_cmd_t                   cmd,
  output slcd_pkg::dp_stat_t                    stat,
  output logic                                  start_hit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [slcd_pkg::BYTE_W-1:0]           out_data,
  output logic                                  out_data_valid,
  output logic                                  out_last,
  output logic [1:0]                            out_status
);
  import slcd_pkg::*;

  logic [CNT_W-1:0]  max_payload_r;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  frame_len_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_data_valid_r;
  logic              out_last_r;
  status_t           out_status_r;

  assign limit = (max_payload_r < LIMIT_MAX) ? max_payload_r : LIMIT_MAX;

  assign start_hit         = (in_rx_byte == START_BYTE);
  assign stat.len_too_long = (in_rx_byte > {1'b0, limit});
  assign stat.len_zero     = (in_rx_byte == '0);
  assign stat.pay_done     = ((cnt_r + CNT_W'(1)) == frame_len_r);
  assign stat.sum_match    = (in_rx_byte == sum_r);
  assign stat.frame_empty  = (frame_len_r == '0);
  assign stat.emit_last    = ((rd_idx_r + CNT_W'(1)) == frame_len_r);
  assign stat.out_busy     = out_valid_r;
  assign stat.out_free     = !out_valid_r || out_ready;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= LIMIT_MAX;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // frame counters and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      sum_r       <= '0;
    end else begin
      if (cmd.ld_len) begin
        frame_len_r <= in_rx_byte[CNT_W-1:0];
        cnt_r       <= '0;
        rd_idx_r    <= '0;
        sum_r       <= in_rx_byte;
      end else if (cmd.pay_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_r + in_rx_byte;
      end
      if (cmd.emit_data) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (cmd.pay_wr) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r[ADDR_W-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_data_r       <= rd_data_r;
      out_data_valid_r <= 1'b1;
      out_last_r       <= stat.emit_last;
      out_status_r     <= ST_GOOD;
    end else if (cmd.emit_status) begin
      out_data_r       <= '0;
      out_data_valid_r <= 1'b0;
      out_last_r       <= 1'b1;
      out_status_r     <= cmd.st_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_data_valid = out_data_valid_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

@@ hw/rtl/sync_length_checksum_deframer_top.sv @@
// ---------------------------------------------------------------------------
// sync_length_checksum_deframer_top
// start byte / length / sum check deframer; stores the payload and releases
// it byte by byte once the check byte matches
// ---------------------------------------------------------------------------
//   channel | direction | payload                                   | beat
//   in_     | input     | rx_byte                                   | one byte
//   out_    | output    | data, data_valid, last, status            | one result
//   cfg_    | input     | max_payload                               | one write
//
// header and payload bytes are taken one per cycle while the output slot is
// not needed; length and check bytes wait while a result sits in the slot
// a good frame drains its payload byte by byte (memory read, then output
// load, which waits while out_ready is low); input is held off meanwhile
// reset clears control state and sets max_payload to 64; no clearing pass
// ---------------------------------------------------------------------------
`include "sync_length_checksum_deframer_top_macros.svh"

module sync_length_checksum_deframer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [slcd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slcd_pkg::BYTE_W-1:0] out_data,
  output logic                        out_data_valid,
  output logic                        out_last,
  output logic [1:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [slcd_pkg::CNT_W-1:0]  cfg_max_payload
);
  import slcd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      start_hit;

  assign cfg_ready = 1'b1;

  slcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_hit (start_hit),
    .stat      (stat),
    .cmd       (cmd)
  );

  slcd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cfg_valid       (cfg_valid),
    .cfg_max_payload (cfg_max_payload),
    .cmd             (cmd),
    .stat            (stat),
    .start_hit       (start_hit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .out_data_valid  (out_data_valid),
    .out_last        (out_last),
    .out_status      (out_status)
  );

  // drain of a frame holds off new bytes until its last beat
  `SLCD_ASSERT_NOW(a_drain_blocks_input, out_valid && out_data_valid && !out_last, !in_ready, "input taken during payload drain")
  // results are loaded only into a free slot
  `SLCD_ASSERT_NOW(a_load_into_free, cmd.emit_data || cmd.emit_status, stat.out_free, "output register overwritten")
  // a loaded payload byte shows up as a good data beat
  `SLCD_ASSERT_NEXT(a_data_beat_good, cmd.emit_data, out_valid && out_data_valid && out_status == ST_GOOD, "payload beat malformed")

endmodule
